// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ----- rtl/srr_pkg.sv -----
package srr_pkg;

  // protocol sizing
  localparam int SEQ_COUNT   = 16;
  localparam int RECV_WINDOW = 8;
  localparam int CHUNK_BYTES = 3;

  // field widths
  localparam int FSEQ_W = 5;
  localparam int DATA_W = 24;
  localparam int LEN_W  = 2;

  // derived sizes
  localparam int SEQ_W   = $clog2(SEQ_COUNT);
  localparam int MAX_RUN = (RECV_WINDOW < SEQ_COUNT) ? RECV_WINDOW : SEQ_COUNT;
  localparam int RUN_W   = $clog2(MAX_RUN + 1);
  localparam int SLOT_W  = DATA_W + LEN_W;

  // result kind codes
  localparam logic KIND_CHUNK = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  // one buffered slot
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } slot_t;

  // clamp the length to the chunk size
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (int'(len) > CHUNK_BYTES) begin
      res = LEN_W'(CHUNK_BYTES);
    end else begin
      res = len;
    end
    return res;
  endfunction

  // byte mask that keeps the first len bytes
  function automatic logic [DATA_W-1:0] chunk_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (b < int'(len)) begin
        mask[b*8 +: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

endpackage

// ----- rtl/srr_ram.sv -----
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/selective_repeat_receiver.sv -----
// channel  | direction | handshake                  | fields
// frame    | in        | frame_valid / frame_stall  | frame_seq, payload_data, payload_len
// result   | out       | result_valid / result_stall| kind, ack_seq, chunk_data, chunk_len, last
//
// one frame at a time: from accept to the next accept the sequencer delivers n chunks
// (0 to 8), each one read of the slot ram plus its registered data, then one ack
// frame_stall is low only while idle; an accepted item inside the window goes into a free slot of the slot ram
// result_stall holds the output register and pauses the sequencer
// synchronous reset clears the slot valid map and the window base; no clearing pass
`include "assert_macros.svh"

module selective_repeat_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_valid,
  output logic                          frame_stall,
  input  logic [srr_pkg::FSEQ_W-1:0]    frame_seq,
  input  logic [srr_pkg::DATA_W-1:0]    payload_data,
  input  logic [srr_pkg::LEN_W-1:0]     payload_len,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          kind,
  output logic [srr_pkg::FSEQ_W-1:0]    ack_seq,
  output logic [srr_pkg::DATA_W-1:0]    chunk_data,
  output logic [srr_pkg::LEN_W-1:0]     chunk_len,
  output logic                          last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDATA,
    S_ACK
  } state_t;

  state_t                         state;
  logic [srr_pkg::SEQ_W-1:0]      base;
  logic [srr_pkg::RUN_W-1:0]      run;
  logic                           deliver;
  logic [srr_pkg::FSEQ_W-1:0]     seq_hold;
  logic [srr_pkg::SEQ_COUNT-1:0]  slot_valid;

  logic                           accept;
  logic                           seq_ok;
  logic [srr_pkg::SEQ_W-1:0]      idx;
  logic [srr_pkg::SEQ_W-1:0]      off;
  logic                           in_win;
  logic                           wr_en;
  srr_pkg::slot_t                 wr_slot;
  srr_pkg::slot_t                 rd_slot;
  logic                           rd_en;
  logic                           out_free;
  logic                           load_res;
  logic [srr_pkg::SEQ_W-1:0]      base_next;
  logic [srr_pkg::LEN_W-1:0]      len_sat;

  assign frame_stall = (state != S_IDLE);
  assign accept      = frame_valid && !frame_stall;
  assign out_free    = !result_valid || !result_stall;
  assign load_res    = out_free && ((state == S_RDATA) || (state == S_ACK));

  // window check of the arriving frame
  always_comb begin
    seq_ok = (frame_seq != '0) && (int'(frame_seq) <= srr_pkg::SEQ_COUNT);
    idx    = srr_pkg::SEQ_W'(frame_seq - srr_pkg::FSEQ_W'(1));
    if (idx >= base) begin
      off = idx - base;
    end else begin
      off = srr_pkg::SEQ_W'(int'(idx) + srr_pkg::SEQ_COUNT - int'(base));
    end
    in_win = seq_ok && (int'(off) < srr_pkg::RECV_WINDOW);
  end

  // chunk store on accept, only into a free slot inside the window
  always_comb begin
    len_sat      = srr_pkg::sat_len(payload_len);
    wr_slot.len  = len_sat;
    wr_slot.data = payload_data & srr_pkg::chunk_mask(len_sat);
    wr_en        = accept && in_win && !slot_valid[idx];
  end

  // next slot to deliver and its read
  always_comb begin
    if (int'(base) == srr_pkg::SEQ_COUNT - 1) begin
      base_next = '0;
    end else begin
      base_next = base + srr_pkg::SEQ_W'(1);
    end
    rd_en = (state == S_SCAN) && deliver && (int'(run) < srr_pkg::MAX_RUN) &&
            slot_valid[base];
  end

  srr_ram #(
    .WIDTH(srr_pkg::SLOT_W),
    .DEPTH(srr_pkg::SEQ_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx),
    .wdata (wr_slot),
    .re    (rd_en),
    .raddr (base),
    .rdata (rd_slot)
  );

  // sequencer, slot map and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      base         <= '0;
      run          <= '0;
      deliver      <= 1'b0;
      slot_valid   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !load_res) begin
        result_valid <= 1'b0;
      end
      if (wr_en) begin
        slot_valid[idx] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            seq_hold <= frame_seq;
            deliver  <= in_win && (idx == base);
            run      <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            slot_valid[base] <= 1'b0;
            base             <= base_next;
            run              <= run + srr_pkg::RUN_W'(1);
            state            <= S_RDATA;
          end else begin
            state <= S_ACK;
          end
        end
        S_RDATA: begin
          if (out_free) begin
            result_valid <= 1'b1;
            kind         <= srr_pkg::KIND_CHUNK;
            ack_seq      <= '0;
            chunk_data   <= rd_slot.data;
            chunk_len    <= rd_slot.len;
            last         <= 1'b0;
            state        <= S_SCAN;
          end
        end
        S_ACK: begin
          if (out_free) begin
            result_valid <= 1'b1;
            kind         <= srr_pkg::KIND_ACK;
            ack_seq      <= seq_hold;
            chunk_data   <= '0;
            chunk_len    <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_PROP(a_read_held_slot, clk, rst, rd_en |-> slot_valid[base])
  `ASSERT_PROP(a_run_bound, clk, rst, int'(run) <= srr_pkg::MAX_RUN)
  `ASSERT_NEVER(a_write_while_busy, clk, rst, wr_en && (state != S_IDLE))
  `ASSERT_PROP(a_ack_frees_input, clk, rst, (state == S_ACK && out_free) |=> !frame_stall)
  `ASSERT_PROP(a_chunk_after_read, clk, rst, rd_en |=> (state == S_RDATA))

endmodule
